// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; used by the queue top level.
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef logic [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the queue entries.
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue top level: request sequencer, one shared compare
// and the output register. Depends on spq_pkg and spq_ram.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, action_i, value_i        | in
//   out     | out_valid_o, out_stall_i, result_value_o,        | out
//           | status_o, entry_count_o, last_o                  |
//
// The single RAM port moves one entry per cycle: insert reads the tail,
// then shifts each smaller entry back until the value drops in; remove
// reads the front, then moves each later entry forward; list reads the
// first, then gives one per cycle while the output is not stalled. Full,
// empty, unused requests and inserts into an empty queue emit directly.
// Reset clears the count and the sequencer; entries need no clearing.
// A stalled output holds the sequencer only where it has a result to give;
// a new request is taken while the last result still waits.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic signed [31:0] value_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic signed [31:0] result_value_o,
  output      logic [1:0]  status_o,
  output      logic [6:0]  entry_count_o,
  output      logic        last_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CW1 = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_FRONT,
    S_REM_MV,
    S_LST_OUT,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    idx_q, idx_d;
  spq_pkg::data_t   val_q, val_d;
  spq_pkg::data_t   res_val_q, res_val_d;
  spq_pkg::status_e res_sts_q, res_sts_d;

  logic             out_valid_q, out_valid_d;
  spq_pkg::data_t   out_val_q, out_val_d;
  spq_pkg::status_e out_sts_q, out_sts_d;
  logic [spq_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  spq_pkg::data_t   ram_wdata, ram_rdata;

  logic             in_accept, out_free, val_gt;
  spq_pkg::action_e act;

  spq_ram #(
    .WIDTH (spq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign act        = spq_pkg::action_e'(action_i);
  // the one shared comparator
  assign val_gt     = $signed(val_q) > $signed(ram_rdata);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    val_d       = val_q;
    res_val_d   = res_val_q;
    res_sts_d   = res_sts_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_sts_d   = out_sts_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = val_q;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          val_d     = spq_pkg::data_t'(value_i);
          res_val_d = '0;
          res_sts_d = spq_pkg::STS_OK;
          state_d   = S_EMIT;
          case (act)
            spq_pkg::ACT_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_sts_d = spq_pkg::STS_FULL;
              end else if (cnt_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = spq_pkg::data_t'(value_i);
                cnt_d     = cnt_q + CW'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IW'(cnt_q - CW'(1));
                idx_d     = IW'(cnt_q);
                state_d   = S_INS_CMP;
              end
            end
            spq_pkg::ACT_REMOVE: begin
              if (cnt_q == '0) begin
                res_sts_d = spq_pkg::STS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_REM_FRONT;
              end
            end
            spq_pkg::ACT_LIST: begin
              if (cnt_q == '0) begin
                res_sts_d = spq_pkg::STS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_LST_OUT;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_CMP: begin
        // shift the smaller entry back one slot, or drop the value in
        ram_we = 1'b1;
        if (val_gt) begin
          ram_waddr = idx_q;
          ram_wdata = ram_rdata;
          idx_d     = idx_q - IW'(1);
          if (idx_q == IW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - IW'(2);
          end
        end else begin
          ram_waddr = idx_q;
          ram_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_EMIT;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_EMIT;
      end

      S_REM_FRONT: begin
        res_val_d = ram_rdata;
        idx_d     = '0;
        if (cnt_q == CW'(1)) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(1);
          state_d   = S_REM_MV;
        end
      end

      S_REM_MV: begin
        // move entry idx+1 forward into idx
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if ((CW1'(idx_q) + CW1'(2)) == CW1'(cnt_q)) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + IW'(2);
          idx_d     = idx_q + IW'(1);
        end
      end

      S_LST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = ram_rdata;
          out_sts_d   = spq_pkg::STS_OK;
          out_cnt_d   = spq_pkg::COUNT_W'(cnt_q);
          out_last_d  = (CW1'(idx_q) + CW1'(1)) == CW1'(cnt_q);
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + IW'(1);
            idx_d     = idx_q + IW'(1);
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_sts_d   = res_sts_q;
          out_cnt_d   = spq_pkg::COUNT_W'(cnt_q);
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      res_val_q   <= '0;
      res_sts_q   <= spq_pkg::STS_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_sts_q   <= spq_pkg::STS_OK;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      val_q       <= val_d;
      res_val_q   <= res_val_d;
      res_sts_q   <= res_sts_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_sts_q   <= out_sts_d;
      out_cnt_q   <= out_cnt_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(out_val_q);
  assign status_o       = out_sts_q;
  assign entry_count_o  = out_cnt_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// ===== test/tb_sorted_priority_queue.sv =====
// Self-checking testbench for sorted_priority_queue: directed and random requests
// against a behavioral copy of the sorted queue, with random gaps and back-pressure.
// Depends on spq_pkg and the queue RTL.
`default_nettype none

module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef struct {
    logic signed [31:0] value;
    spq_pkg::status_e   status;
    logic [6:0]         count;
    logic               last;
  } queue_result_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  spq_pkg::action_e   action      = spq_pkg::ACT_INSERT;
  logic signed [31:0] value       = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [6:0]         entry_count;
  logic               last;

  // behavioral copy of the queue contents
  logic signed [31:0] model_entries [DEPTH];
  int unsigned        model_count = 0;
  queue_result_t      pending_results [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          gaps_enabled   = 1'b1;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_pct      = 0;
  int unsigned stall_phase    = 0;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status),
    .entry_count_o  (entry_count),
    .last_o         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Work out the results one accepted request causes and queue them.
  function automatic void predict_queue_op(spq_pkg::action_e act, logic signed [31:0] val);
    queue_result_t r;
    int i;
    r.value  = '0;
    r.status = spq_pkg::STS_OK;
    r.last   = 1'b1;
    case (act)
      spq_pkg::ACT_INSERT: begin
        if (model_count >= DEPTH) begin
          r.status = spq_pkg::STS_FULL;
        end else begin
          // shift smaller entries back; equal ones stay ahead
          i = model_count;
          while (i > 0 && val > model_entries[i-1]) begin
            model_entries[i] = model_entries[i-1];
            i--;
          end
          model_entries[i] = val;
          model_count++;
        end
        r.count = 7'(model_count);
        pending_results.push_back(r);
      end
      spq_pkg::ACT_REMOVE: begin
        if (model_count == 0) begin
          r.status = spq_pkg::STS_EMPTY;
        end else begin
          r.value = model_entries[0];
          for (i = 0; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
        r.count = 7'(model_count);
        pending_results.push_back(r);
      end
      spq_pkg::ACT_LIST: begin
        r.count = 7'(model_count);
        if (model_count == 0) begin
          r.status = spq_pkg::STS_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (i = 0; i < model_count; i++) begin
            r.value = model_entries[i];
            r.last  = (i + 1 == model_count);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        r.count = 7'(model_count);
        pending_results.push_back(r);
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // Offer one request in bursts with random gaps; predict once accepted.
  task automatic send_request(input spq_pkg::action_e act, input logic signed [31:0] val);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_enabled ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (in_stall);
    predict_queue_op(act, val);
  endtask

  // Receiver: stall pattern that changes at random intervals, plus long holds.
  always @(negedge clk) begin : drive_stall
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_phase = $urandom_range(20, 80);
    end
    stall_phase--;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value)
          report_mismatch("result_value", result_value, want.value);
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (entry_count !== want.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
        if (last !== want.last)
          report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  task automatic test_empty_queue();
    send_request(spq_pkg::ACT_REMOVE, 32'sh0);
    send_request(spq_pkg::ACT_LIST, 32'shffffffff);
    send_request(spq_pkg::ACT_NONE, 32'sh0);
  endtask

  task automatic test_order_and_full();
    int k;
    send_request(spq_pkg::ACT_INSERT, 32'sd5);
    send_request(spq_pkg::ACT_INSERT, 32'sh80000000);
    send_request(spq_pkg::ACT_INSERT, 32'sh7fffffff);
    send_request(spq_pkg::ACT_INSERT, -32'sd1);
    send_request(spq_pkg::ACT_INSERT, 32'sd0);
    send_request(spq_pkg::ACT_INSERT, 32'sd5);
    send_request(spq_pkg::ACT_INSERT, 32'sd1);
    send_request(spq_pkg::ACT_INSERT, -32'sd1);
    // queue is full now
    send_request(spq_pkg::ACT_INSERT, 32'sd42);
    send_request(spq_pkg::ACT_LIST, 32'sh0);
    send_request(spq_pkg::ACT_NONE, 32'shffffffff);
    for (k = 0; k < DEPTH; k++) send_request(spq_pkg::ACT_REMOVE, 32'sh0);
    send_request(spq_pkg::ACT_REMOVE, 32'sh0);
  endtask

  task automatic test_random_traffic();
    int n;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned rem_pct;
    spq_pkg::action_e act;
    gaps_enabled = 1'b1;
    for (n = 0; n < 165; n++) begin
      // alternate fill-heavy and drain-heavy stretches to hit full and empty
      ins_pct = ((n / 30) % 2 == 0) ? 65 : 20;
      rem_pct = ((n / 30) % 2 == 0) ? 15 : 60;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) act = spq_pkg::ACT_INSERT;
      else if (roll < ins_pct + rem_pct) act = spq_pkg::ACT_REMOVE;
      else if (roll < 95) act = spq_pkg::ACT_LIST;
      else act = spq_pkg::ACT_NONE;
      send_request(act, pick_value());
    end
  endtask

  task automatic test_backpressure();
    int k;
    gaps_enabled = 1'b0;
    hold_req = 300;
    // fill, then pile up list requests while the receiver holds off
    for (k = 0; k < 24; k++) begin
      if (k < 10) send_request(spq_pkg::ACT_INSERT, pick_value());
      else if (k % 4 == 3) send_request(spq_pkg::ACT_REMOVE, pick_value());
      else send_request(spq_pkg::ACT_LIST, pick_value());
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_order_and_full();
    test_random_traffic();
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
